@@ sv/vrsq_pkg.sv @@
// shared types and constants of the vruntime run queue
// request and result payloads, action and status codes, controller/datapath links
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vrsq_pkg;

  localparam int KEY_BITS     = 64;
  localparam int TASK_BITS    = 8;
  localparam int CNT_OUT_BITS = 5;

  // request actions
  localparam logic [1:0] ACT_ENQ  = 2'd0;
  localparam logic [1:0] ACT_REM  = 2'd1;
  localparam logic [1:0] ACT_POP  = 2'd2;
  localparam logic [1:0] ACT_PEEK = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_DUP       = 3'd4;

  // walk index updates
  localparam logic [2:0] IDX_HOLD  = 3'd0;
  localparam logic [2:0] IDX_INC   = 3'd1;
  localparam logic [2:0] IDX_DEC   = 3'd2;
  localparam logic [2:0] IDX_TOP   = 3'd3;
  localparam logic [2:0] IDX_AFTER = 3'd4;

  typedef struct packed {
    logic [1:0]          action;
    logic [TASK_BITS-1:0] task_id;
    logic [KEY_BITS-1:0]  runtime_key;
  } vrsq_in_t;

  typedef struct packed {
    logic [2:0]              status;
    logic                    head_valid;
    logic [TASK_BITS-1:0]    head_id;
    logic [KEY_BITS-1:0]     head_runtime;
    logic [CNT_OUT_BITS-1:0] entry_count;
  } vrsq_out_t;

  typedef struct packed {
    logic       cap;
    logic [2:0] idx_op;
    logic       cmp;
    logic       mv;
    logic       mv_up;
    logic       ins;
    logic       head_ld;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       out_ld;
    logic [2:0] status;
    logic       head_valid;
  } vrsq_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       idx_lt_cnt;
    logic       idx_eq_ins;
    logic       cnt_zero;
    logic       cnt_full;
    logic       found;
    logic       ins_end;
    logic       out_free;
  } vrsq_stat_t;

endpackage

`default_nettype wire

@@ sv/vrsq_dpath.sv @@
// datapath of the vruntime run queue: entry memory, walk index, scan results,
// head capture, entry count and result register; uses vrsq_pkg
`timescale 1ns / 1ps
`default_nettype none

module vrsq_dpath #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  vrsq_pkg::vrsq_in_t   in_data,
  input  wire                  out_stall,
  input  vrsq_pkg::vrsq_cmd_t  cmd,
  output vrsq_pkg::vrsq_stat_t stat,
  output logic                 out_valid,
  output vrsq_pkg::vrsq_out_t  out_data
);

  localparam int IDW   = (ID_BITS < vrsq_pkg::TASK_BITS) ? ID_BITS : vrsq_pkg::TASK_BITS;
  localparam int KW    = vrsq_pkg::KEY_BITS;
  localparam int ENT_W = IDW + KW;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_data_r;

  logic [1:0]       act_r;
  logic [IDW-1:0]   req_id_r;
  logic [KW-1:0]    req_key_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             found_r;
  logic [IDX_W-1:0] found_pos_r;
  logic [CNT_W-1:0] ins_cnt_r;
  logic             cmp_v_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             mv_v_r;
  logic [IDX_W-1:0] mv_dst_r, mv_dst_nxt;
  logic [IDW-1:0]   head_id_r;
  logic [KW-1:0]    head_key_r;
  logic             out_valid_r;
  vrsq_pkg::vrsq_out_t out_r, out_nxt;

  logic [IDX_W-1:0] rd_addr;
  logic [IDW-1:0]   rd_id;
  logic [KW-1:0]    rd_key;

  assign rd_addr = idx_r[IDX_W-1:0];
  assign rd_id   = rd_data_r[ENT_W-1:KW];
  assign rd_key  = rd_data_r[KW-1:0];

  // single write port: a pending move wins, the controller never overlaps an insert
  always_ff @(posedge clk) begin
    if (mv_v_r) begin
      mem[mv_dst_r] <= rd_data_r;
    end else if (cmd.ins) begin
      mem[ins_cnt_r[IDX_W-1:0]] <= {req_id_r, req_key_r};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.cap) begin
      idx_nxt = '0;
    end else begin
      case (cmd.idx_op)
        vrsq_pkg::IDX_INC:   idx_nxt = idx_r + CNT_W'(1);
        vrsq_pkg::IDX_DEC:   idx_nxt = idx_r - CNT_W'(1);
        vrsq_pkg::IDX_TOP:   idx_nxt = cnt_r - CNT_W'(1);
        vrsq_pkg::IDX_AFTER: idx_nxt = CNT_W'(found_pos_r) + CNT_W'(1);
        default:             idx_nxt = idx_r;
      endcase
    end
  end

  assign mv_dst_nxt = cmd.mv_up ? (rd_addr + IDX_W'(1)) : (rd_addr - IDX_W'(1));

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cmp_idx_r <= rd_addr;
    mv_dst_r  <= mv_dst_nxt;
    if (cmd.cap) begin
      act_r       <= in_data.action;
      req_id_r    <= in_data.task_id[IDW-1:0];
      req_key_r   <= in_data.runtime_key;
      found_r     <= 1'b0;
      found_pos_r <= '0;
      ins_cnt_r   <= '0;
    end else if (cmp_v_r) begin
      if (rd_id == req_id_r) begin
        found_r     <= 1'b1;
        found_pos_r <= cmp_idx_r;
      end
      // count of keys not above the new one is the insertion slot
      if (rd_key <= req_key_r) begin
        ins_cnt_r <= ins_cnt_r + CNT_W'(1);
      end
    end
    if (cmd.head_ld) begin
      head_id_r  <= rd_id;
      head_key_r <= rd_key;
    end
    if (cmd.out_ld) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      cmp_v_r     <= 1'b0;
      mv_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_v_r <= cmd.cmp;
      mv_v_r  <= cmd.mv;
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    out_nxt.status       = cmd.status;
    out_nxt.head_valid   = cmd.head_valid;
    out_nxt.head_id      = cmd.head_valid ? vrsq_pkg::TASK_BITS'(head_id_r) : '0;
    out_nxt.head_runtime = cmd.head_valid ? head_key_r : '0;
    out_nxt.entry_count  = vrsq_pkg::CNT_OUT_BITS'(cnt_r);
  end

  assign stat.action     = act_r;
  assign stat.idx_lt_cnt = (idx_r < cnt_r);
  assign stat.idx_eq_ins = (idx_r == ins_cnt_r);
  assign stat.cnt_zero   = (cnt_r == '0);
  assign stat.cnt_full   = (cnt_r == CNT_W'(DEPTH));
  assign stat.found      = found_r;
  assign stat.ins_end    = (ins_cnt_r == cnt_r);
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ sv/vrsq_ctrl.sv @@
// controller of the vruntime run queue: sequences scan, head, shift, insert and result
// steps of one request; uses vrsq_pkg
`timescale 1ns / 1ps
`default_nettype none

module vrsq_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  vrsq_pkg::vrsq_stat_t stat,
  output vrsq_pkg::vrsq_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_HEAD   = 4'd3;
  localparam logic [3:0] S_SHUP   = 4'd4;
  localparam logic [3:0] S_SHDN   = 4'd5;
  localparam logic [3:0] S_FLUSH  = 4'd6;
  localparam logic [3:0] S_INSERT = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [2:0] st_r, st_nxt;
  logic       hv_r, hv_nxt;
  logic       scan_act;

  assign scan_act = (stat.action == vrsq_pkg::ACT_ENQ) || (stat.action == vrsq_pkg::ACT_REM);

  always_comb begin
    state_nxt  = state_r;
    st_nxt     = st_r;
    hv_nxt     = hv_r;
    cmd        = '0;
    cmd.idx_op = vrsq_pkg::IDX_HOLD;
    cmd.status     = st_r;
    cmd.head_valid = hv_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          st_nxt    = vrsq_pkg::ST_OK;
          hv_nxt    = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_act && stat.idx_lt_cnt) begin
          cmd.cmp    = 1'b1;
          cmd.idx_op = vrsq_pkg::IDX_INC;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (stat.action)
          vrsq_pkg::ACT_ENQ: begin
            if (stat.found) begin
              st_nxt    = vrsq_pkg::ST_DUP;
              state_nxt = S_DONE;
            end else if (stat.cnt_full) begin
              st_nxt    = vrsq_pkg::ST_FULL;
              state_nxt = S_DONE;
            end else if (stat.ins_end) begin
              state_nxt = S_INSERT;
            end else begin
              cmd.idx_op = vrsq_pkg::IDX_TOP;
              state_nxt  = S_SHUP;
            end
          end
          vrsq_pkg::ACT_REM: begin
            if (!stat.found) begin
              st_nxt    = vrsq_pkg::ST_NOT_FOUND;
              state_nxt = S_DONE;
            end else begin
              cmd.idx_op = vrsq_pkg::IDX_AFTER;
              state_nxt  = S_SHDN;
            end
          end
          default: begin
            if (stat.cnt_zero) begin
              st_nxt    = vrsq_pkg::ST_EMPTY;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_HEAD;
            end
          end
        endcase
      end
      S_HEAD: begin
        cmd.head_ld = 1'b1;
        hv_nxt      = 1'b1;
        if (stat.action == vrsq_pkg::ACT_PEEK) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_op = vrsq_pkg::IDX_AFTER;
          state_nxt  = S_SHDN;
        end
      end
      S_SHUP: begin
        cmd.mv    = 1'b1;
        cmd.mv_up = 1'b1;
        if (stat.idx_eq_ins) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.idx_op = vrsq_pkg::IDX_DEC;
        end
      end
      S_SHDN: begin
        if (stat.idx_lt_cnt) begin
          cmd.mv     = 1'b1;
          cmd.idx_op = vrsq_pkg::IDX_INC;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (stat.action == vrsq_pkg::ACT_ENQ) begin
          state_nxt = S_INSERT;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_INSERT: begin
        cmd.ins     = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= vrsq_pkg::ST_OK;
      hv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      hv_r    <= hv_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

@@ sv/vruntime_sorted_run_queue.sv @@
// top level of the vruntime run queue: controller plus datapath
// depends on vrsq_pkg, vrsq_ctrl and vrsq_dpath
`timescale 1ns / 1ps
`default_nettype none

// Run queue of up to DEPTH tasks held in one entry memory, with one read and one write
// port, in ascending runtime order, ties kept in arrival order. One request at a time:
// enqueue, remove by id, pop the head or peek the head; every request gives exactly one
// result with a status and the entry count after the request. Duplicate ids (checked
// before full), enqueue on a full queue, removal of an absent id and pop or peek on an
// empty queue change nothing and report their status. The memory needs no clearing
// after reset: only entries below the count are ever read. An enqueue or a remove walks
// the memory with one read and one write per cycle: a full scan compares every entry for
// the id and the insertion slot, then the entries above the slot, or after the removed
// entry, move one place, one per cycle; a pop also moves the entries after the head.
// A finished result waits in the output register, and the next request is accepted
// while it waits.

module vruntime_sorted_run_queue #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  // request channel
  input  wire                 in_valid,
  output logic                in_stall,
  input  vrsq_pkg::vrsq_in_t  in_data,
  // result channel
  output logic                out_valid,
  input  wire                 out_stall,
  output vrsq_pkg::vrsq_out_t out_data
);

  // command and status between sequencer and datapath
  vrsq_pkg::vrsq_cmd_t  cmd;
  vrsq_pkg::vrsq_stat_t stat;

  // sequencer: one request walks scan, decide, head, shift, insert and result steps
  vrsq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: sorted entry memory, count and the result register
  vrsq_dpath #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // head fields only accompany a successful pop or peek
  a_head_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.head_valid) |-> (out_data.status == vrsq_pkg::ST_OK))
    else $error("head reported with a failing status");

  // head fields are zero when not meaningful
  a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.head_valid) |->
      ((out_data.head_id == '0) && (out_data.head_runtime == '0)))
    else $error("head fields not cleared without a head");

  // a fresh result means the sequencer is back to taking requests
  a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result delivered while the sequencer is still busy");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// self-checking testbench for the vruntime run queue: directed corner requests, then random
// traffic under sender and receiver idling, each result checked against a sorted-list mirror
// depends on vrsq_pkg and vruntime_sorted_run_queue
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH      = 16;
  localparam int ID_BITS    = 8;
  localparam int IDLE_LIMIT = 5000;   // cycles with no request or result moving
  localparam int DRAIN_WAIT = 64;     // settle time after the last expected result, to cover the longest walk

  // only the low ID_BITS bits of a task id take part
  localparam logic [vrsq_pkg::TASK_BITS-1:0] ID_MASK =
    vrsq_pkg::TASK_BITS'((1 << ID_BITS) - 1);

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  vrsq_pkg::vrsq_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  vrsq_pkg::vrsq_out_t out_data;

  vruntime_sorted_run_queue #(
    .DEPTH  (DEPTH),
    .ID_BITS(ID_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // mirror of the run queue: ids and keys in ascending key order, ties in arrival order
  logic [vrsq_pkg::TASK_BITS-1:0] mirror_ids  [DEPTH];
  logic [vrsq_pkg::KEY_BITS-1:0]  mirror_keys [DEPTH];
  int                             mirror_count = 0;

  vrsq_pkg::vrsq_out_t pending_results[$];   // expected results, oldest first
  int                  error_count   = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  idle_cycles   = 0;
  bit                  fill_mode     = 1'b1; // random traffic leans toward enqueue while set

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // mirror of the queue
  // ---------------------------------------------------------------------------

  // close the gap left by the entry at pos
  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < mirror_count; i++) begin
      mirror_ids[i]  = mirror_ids[i + 1];
      mirror_keys[i] = mirror_keys[i + 1];
    end
    mirror_count--;
  endfunction

  // apply one request to the mirror and return the result the block must give
  function automatic vrsq_pkg::vrsq_out_t runq_apply(vrsq_pkg::vrsq_in_t req);
    vrsq_pkg::vrsq_out_t            res;
    logic [vrsq_pkg::TASK_BITS-1:0] id;
    int                             hit;
    int                             pos;
    res = '0;
    res.status = vrsq_pkg::ST_OK;
    id  = req.task_id & ID_MASK;
    hit = -1;
    // id lookup first, the duplicate check wins over the full check
    for (int i = 0; i < mirror_count; i++)
      if (hit < 0 && mirror_ids[i] == id) hit = i;
    case (req.action)
      vrsq_pkg::ACT_ENQ: begin
        if (hit >= 0) begin
          res.status = vrsq_pkg::ST_DUP;
        end else if (mirror_count >= DEPTH) begin
          res.status = vrsq_pkg::ST_FULL;
        end else begin
          // slot after the last key that is less than or equal to the new one
          pos = 0;
          while (pos < mirror_count && mirror_keys[pos] <= req.runtime_key) pos++;
          for (int i = mirror_count; i > pos; i--) begin
            mirror_ids[i]  = mirror_ids[i - 1];
            mirror_keys[i] = mirror_keys[i - 1];
          end
          mirror_ids[pos]  = id;
          mirror_keys[pos] = req.runtime_key;
          mirror_count++;
        end
      end
      vrsq_pkg::ACT_REM: begin
        if (hit < 0) res.status = vrsq_pkg::ST_NOT_FOUND;
        else drop_entry(hit);
      end
      default: begin
        // pop and peek both report the head
        if (mirror_count == 0) begin
          res.status = vrsq_pkg::ST_EMPTY;
        end else begin
          res.head_valid   = 1'b1;
          res.head_id      = mirror_ids[0];
          res.head_runtime = mirror_keys[0];
          if (req.action == vrsq_pkg::ACT_POP) drop_entry(0);
        end
      end
    endcase
    res.entry_count = vrsq_pkg::CNT_OUT_BITS'(mirror_count);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // idle for random cycles at the rate of the current phase, then hold the request until taken
  task automatic send_request(vrsq_pkg::vrsq_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(runq_apply(req));
  endtask

  function automatic vrsq_pkg::vrsq_in_t make_request(
    logic [1:0] act, logic [vrsq_pkg::TASK_BITS-1:0] id, logic [vrsq_pkg::KEY_BITS-1:0] key);
    vrsq_pkg::vrsq_in_t req;
    req.action      = act;
    req.task_id     = id;
    req.runtime_key = key;
    return req;
  endfunction

  // mostly well-formed traffic: removes aim at queued ids, keys often tie with queued ones
  function automatic vrsq_pkg::vrsq_in_t build_random_request();
    vrsq_pkg::vrsq_in_t req;
    int                 roll;
    int                 key_roll;
    req.task_id     = vrsq_pkg::TASK_BITS'($urandom_range(255));
    req.runtime_key = {$urandom, $urandom};
    roll = $urandom_range(99);
    if (fill_mode)
      req.action = roll < 70 ? vrsq_pkg::ACT_ENQ :
                   roll < 80 ? vrsq_pkg::ACT_REM :
                   roll < 90 ? vrsq_pkg::ACT_POP : vrsq_pkg::ACT_PEEK;
    else
      req.action = roll < 15 ? vrsq_pkg::ACT_ENQ :
                   roll < 55 ? vrsq_pkg::ACT_REM :
                   roll < 90 ? vrsq_pkg::ACT_POP : vrsq_pkg::ACT_PEEK;
    roll = $urandom_range(99);
    // noise: fully random request
    if (roll < 8) return req;
    case (req.action)
      vrsq_pkg::ACT_ENQ: begin
        // now and then reuse a queued id to provoke a duplicate
        if (mirror_count > 0 && roll < 20)
          req.task_id = mirror_ids[$urandom_range(mirror_count - 1)];
        key_roll = $urandom_range(99);
        if (key_roll < 25)
          req.runtime_key = vrsq_pkg::KEY_BITS'($urandom_range(7));
        else if (key_roll < 40 && mirror_count > 0)
          req.runtime_key = mirror_keys[$urandom_range(mirror_count - 1)];
        else if (key_roll < 50)
          req.runtime_key = $urandom_range(1) ? '1 : '0;
      end
      vrsq_pkg::ACT_REM: begin
        if (mirror_count > 0 && roll < 75)
          req.task_id = mirror_ids[$urandom_range(mirror_count - 1)];
      end
      default: ;
    endcase
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver stall, random at the rate of the current phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    vrsq_pkg::vrsq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d entry_count %0d",
               out_data.status, out_data.entry_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.head_valid !== want.head_valid) begin
          $error("head_valid: expected %0d, got %0d", want.head_valid, out_data.head_valid);
          error_count++;
        end
        if (out_data.head_id !== want.head_id) begin
          $error("head_id: expected %0h, got %0h", want.head_id, out_data.head_id);
          error_count++;
        end
        if (out_data.head_runtime !== want.head_runtime) begin
          $error("head_runtime: expected %0h, got %0h", want.head_runtime,
                 out_data.head_runtime);
          error_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_data.entry_count);
          error_count++;
        end
      end
    end
  end

  // watchdog: too long with neither a request nor a result moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("vruntime_sorted_run_queue regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // pop, peek and remove on an empty queue
  task automatic test_empty_queue();
    send_request(make_request(vrsq_pkg::ACT_POP, 8'h00, '0));
    send_request(make_request(vrsq_pkg::ACT_PEEK, 8'hFF, '1));
    send_request(make_request(vrsq_pkg::ACT_REM, 8'h3C, '0));
  endtask

  // fill to capacity with extreme and tied keys, then full and duplicate refusals
  task automatic test_fill_to_full();
    send_request(make_request(vrsq_pkg::ACT_ENQ, 8'hFF, '1));
    send_request(make_request(vrsq_pkg::ACT_ENQ, 8'h00, '0));
    // duplicate id on a queue that still has room
    send_request(make_request(vrsq_pkg::ACT_ENQ, 8'hFF, 64'd5));
    send_request(make_request(vrsq_pkg::ACT_ENQ, 8'hA5, 64'd5));
    // equal keys go after the earlier arrival
    send_request(make_request(vrsq_pkg::ACT_ENQ, 8'h5A, 64'd5));
    send_request(make_request(vrsq_pkg::ACT_ENQ, 8'h01, '1));
    send_request(make_request(vrsq_pkg::ACT_ENQ, 8'h80, '0));
    for (int i = 0; i < DEPTH - 6; i++)
      send_request(make_request(vrsq_pkg::ACT_ENQ, vrsq_pkg::TASK_BITS'(8'h10 + i),
                                64'h8000_0000_0000_0000 >> (i * 6)));
    // full: a new id is refused
    send_request(make_request(vrsq_pkg::ACT_ENQ, 8'h77, 64'd1));
    // full and duplicate at once: duplicate is reported
    send_request(make_request(vrsq_pkg::ACT_ENQ, 8'h00, 64'd1));
  endtask

  // remove of an absent id, remove from the middle, then peek and pop the head
  task automatic test_remove_and_pop();
    send_request(make_request(vrsq_pkg::ACT_REM, 8'h77, '0));
    send_request(make_request(vrsq_pkg::ACT_REM, 8'hA5, '1));
    send_request(make_request(vrsq_pkg::ACT_PEEK, 8'h00, '0));
    send_request(make_request(vrsq_pkg::ACT_POP, 8'h00, '0));
  endtask

  // random traffic, switching between filling and draining the queue
  task automatic test_random_traffic(int n_req, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < n_req; k++) begin
      if ($urandom_range(39) == 0) fill_mode = !fill_mode;
      send_request(build_random_request());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_fill_to_full();
    test_remove_and_pop();
    test_random_traffic(550, 38, 70);
    test_random_traffic(550, 70, 38);
    test_random_traffic(550, 0, 0);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("vruntime_sorted_run_queue regression: pass");
    end else begin
      $display("vruntime_sorted_run_queue regression: fail");
    end
    $finish;
  end

endmodule
